// File: rtl/four_level_page_table_walker_assert.svh
// Assertion macros shared by the page table walker RTL.
// Depends on nothing; defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside of reset.
`define FPTW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define FPTW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FPTW_ASSERT(label, clk, rst_n, prop, msg)
`define FPTW_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/fptw_pkg.sv
// Shared constants, types and helper functions of the page table walker.
// Depends on nothing; the interfaces, controller, datapath and top refer to it by scoped names.
package fptw_pkg;

  // Table store geometry: frames of 512 64-bit words.
  localparam int unsigned TABLE_FRAMES_LOG2 = 6;
  localparam int unsigned TABLE_FRAMES      = 1 << TABLE_FRAMES_LOG2;
  localparam int unsigned TABLE_IDX_W       = 9;
  localparam int unsigned WORDS_PER_TABLE   = 1 << TABLE_IDX_W;
  localparam int unsigned STORE_WORDS       = TABLE_FRAMES * WORDS_PER_TABLE;
  localparam int unsigned FRAME_W           = TABLE_FRAMES_LOG2;
  localparam int unsigned STORE_ADDR_W      = FRAME_W + TABLE_IDX_W;

  // Field widths.
  localparam int unsigned ENTRY_W      = 64;
  localparam int unsigned VA_W         = 64;
  localparam int unsigned WORD_INDEX_W = 15;
  localparam int unsigned PA_W         = 52;
  localparam int unsigned ROOT_W       = 6;
  localparam int unsigned OFFSET_W     = 12;
  localparam int unsigned ENTRY_FRAME_W = PA_W - OFFSET_W;

  // Canonical check: bits CANON_LSB and above all zero or all one.
  localparam int unsigned CANON_LSB = 48;
  localparam int unsigned CANON_W   = VA_W - CANON_LSB;
  localparam logic [CANON_W-1:0] CANON_ONES = 16'hFFFF;

  // Entry bits.
  localparam int unsigned PRESENT_BIT = 0;

  // Item modes.
  localparam logic MODE_WRITE     = 1'b0;
  localparam logic MODE_TRANSLATE = 1'b1;

  // Configuration register map (index from byte address bit 2).
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_ROOT_TABLE_FRAME = 1'b0;

  // Walk levels: PML4, PDP, PD, PT.
  localparam int unsigned LEVEL_W = 2;
  localparam logic [LEVEL_W-1:0] LEVEL_PML4 = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_PDP  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_PD   = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_PT   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WALK
  } state_e;

  typedef enum logic [1:0] {
    ADDR_WRITE,
    ADDR_ROOT,
    ADDR_NEXT
  } addr_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic                ram_we;
    logic                ram_re;
    addr_sel_e           addr_sel;
    logic [LEVEL_W-1:0]  level;
    logic                load_va;
    logic                emit;
    logic                emit_ok;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic canonical;
    logic present;
    logic slot_free;
  } sts_t;

  // Nine-bit table index of the virtual address for a walk level.
  function automatic logic [TABLE_IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                      input logic [LEVEL_W-1:0] level);
    logic [TABLE_IDX_W-1:0] idx;
    case (level)
      LEVEL_PML4: idx = va[47:39];
      LEVEL_PDP:  idx = va[38:30];
      LEVEL_PD:   idx = va[29:21];
      default:    idx = va[20:12];
    endcase
    return idx;
  endfunction

  // Frame number reduced to the store: modulo a power of two is a mask.
  function automatic logic [FRAME_W-1:0] store_frame(input logic [ENTRY_FRAME_W-1:0] frame);
    return frame[FRAME_W-1:0];
  endfunction

endpackage

// File: rtl/fptw_in_if.sv
// Input channel of the page table walker: valid/ready plus one item's fields.
// Depends on fptw_pkg for the field widths.
interface fptw_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic [fptw_pkg::WORD_INDEX_W-1:0]    table_word_index;
  logic [fptw_pkg::ENTRY_W-1:0]         entry_value;
  logic [fptw_pkg::VA_W-1:0]            virt_addr;

  modport source (output valid, mode, table_word_index, entry_value, virt_addr,
                  input ready);
  modport sink   (input valid, mode, table_word_index, entry_value, virt_addr,
                  output ready);
endinterface

// File: rtl/fptw_out_if.sv
// Result channel of the page table walker: valid/ready plus one result's fields.
// Depends on fptw_pkg for the field widths.
interface fptw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       translated;
  logic [fptw_pkg::PA_W-1:0]  phys_addr;

  modport source (output valid, translated, phys_addr, input ready);
  modport sink   (input valid, translated, phys_addr, output ready);
endinterface

// File: rtl/fptw_ram.sv
// Generic single-port RAM with registered read data, held while no read is enabled.
// Depends on nothing.
module fptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fptw_ctrl.sv
// Walk controller: sequences store writes, the four table reads and result issue.
// Depends on fptw_pkg and four_level_page_table_walker_assert.svh.
`include "four_level_page_table_walker_assert.svh"

module fptw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  logic            item_mode_i,
  output logic            item_ready_o,
  input  fptw_pkg::sts_t  sts_i,
  output fptw_pkg::cmd_t  cmd_o
);

  fptw_pkg::state_e                 state_q, state_d;
  logic [fptw_pkg::LEVEL_W-1:0]     level_q, level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fptw_pkg::S_IDLE;
      level_q <= fptw_pkg::LEVEL_PML4;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    level_d         = level_q;
    item_ready_o    = 1'b0;
    cmd_o           = '0;
    cmd_o.addr_sel  = fptw_pkg::ADDR_WRITE;
    cmd_o.level     = level_q;

    unique case (state_q)
      fptw_pkg::S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          if (item_mode_i == fptw_pkg::MODE_WRITE) begin
            cmd_o.ram_we = 1'b1;
          end else begin
            cmd_o.load_va = 1'b1;
            state_d       = fptw_pkg::S_ISSUE;
          end
        end
      end

      fptw_pkg::S_ISSUE: begin
        if (!sts_i.canonical) begin
          // Fault without touching the store; hold until the result slot frees.
          if (sts_i.slot_free) begin
            cmd_o.emit = 1'b1;
            state_d    = fptw_pkg::S_IDLE;
          end
        end else begin
          cmd_o.ram_re   = 1'b1;
          cmd_o.addr_sel = fptw_pkg::ADDR_ROOT;
          cmd_o.level    = fptw_pkg::LEVEL_PML4;
          level_d        = fptw_pkg::LEVEL_PML4;
          state_d        = fptw_pkg::S_WALK;
        end
      end

      fptw_pkg::S_WALK: begin
        if (!sts_i.present || level_q == fptw_pkg::LEVEL_PT) begin
          if (sts_i.slot_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.emit_ok = sts_i.present;
            state_d       = fptw_pkg::S_IDLE;
          end
        end else begin
          // Chain the next read straight off the entry just read.
          cmd_o.ram_re   = 1'b1;
          cmd_o.addr_sel = fptw_pkg::ADDR_NEXT;
          cmd_o.level    = level_q + 2'd1;
          level_d        = level_q + 2'd1;
        end
      end

      default: begin
        state_d = fptw_pkg::S_IDLE;
      end
    endcase
  end

  `FPTW_ASSERT(a_emit_needs_slot, clk_i, rst_ni, cmd_o.emit |-> sts_i.slot_free, "result issued into a full slot")
  `FPTW_ASSERT(a_ok_only_at_leaf, clk_i, rst_ni, (cmd_o.emit && cmd_o.emit_ok) |-> (state_q == fptw_pkg::S_WALK && level_q == fptw_pkg::LEVEL_PT && sts_i.present), "success issued before the leaf level")
  `FPTW_ASSERT(a_read_then_walk, clk_i, rst_ni, cmd_o.ram_re |=> (state_q == fptw_pkg::S_WALK && level_q == $past(cmd_o.level)), "table read not followed by its check")
  `FPTW_ASSERT(a_no_rw_clash, clk_i, rst_ni, !(cmd_o.ram_we && (cmd_o.ram_re || state_q != fptw_pkg::S_IDLE)), "store write outside idle or alongside a read")

endmodule

// File: rtl/fptw_dp.sv
// Walk datapath: table store, address held for the walk, address mux and result register.
// Depends on fptw_pkg and fptw_ram.
module fptw_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fptw_pkg::cmd_t                      cmd_i,
  output fptw_pkg::sts_t                      sts_o,
  input  logic [fptw_pkg::WORD_INDEX_W-1:0]   table_word_index_i,
  input  logic [fptw_pkg::ENTRY_W-1:0]        entry_value_i,
  input  logic [fptw_pkg::VA_W-1:0]           virt_addr_i,
  input  logic [fptw_pkg::ROOT_W-1:0]         root_table_frame_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                out_translated_o,
  output logic [fptw_pkg::PA_W-1:0]           out_phys_addr_o
);

  logic [fptw_pkg::VA_W-1:0]          va_q;
  logic [fptw_pkg::STORE_ADDR_W-1:0]  ram_addr;
  logic [fptw_pkg::ENTRY_W-1:0]       ram_rdata;
  logic [31:0]                        wr_idx;
  logic                               wr_in_range;
  logic [fptw_pkg::ENTRY_FRAME_W-1:0] entry_frame;
  logic                               out_valid_q;
  logic                               out_translated_q;
  logic [fptw_pkg::PA_W-1:0]          out_pa_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_va) begin
      va_q <= virt_addr_i;
    end
  end

  assign wr_idx      = 32'(table_word_index_i);
  assign wr_in_range = wr_idx < 32'(fptw_pkg::STORE_WORDS);
  assign entry_frame = ram_rdata[fptw_pkg::PA_W-1:fptw_pkg::OFFSET_W];

  always_comb begin
    unique case (cmd_i.addr_sel)
      fptw_pkg::ADDR_ROOT: begin
        ram_addr = {fptw_pkg::store_frame(fptw_pkg::ENTRY_FRAME_W'(root_table_frame_i)),
                    fptw_pkg::va_index(va_q, cmd_i.level)};
      end
      fptw_pkg::ADDR_NEXT: begin
        ram_addr = {fptw_pkg::store_frame(entry_frame),
                    fptw_pkg::va_index(va_q, cmd_i.level)};
      end
      default: begin
        ram_addr = wr_idx[fptw_pkg::STORE_ADDR_W-1:0];
      end
    endcase
  end

  fptw_ram #(
    .WIDTH (fptw_pkg::ENTRY_W),
    .DEPTH (fptw_pkg::STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we && wr_in_range),
    .re_i    (cmd_i.ram_re),
    .addr_i  (ram_addr),
    .wdata_i (entry_value_i),
    .rdata_o (ram_rdata)
  );

  assign sts_o.canonical = (va_q[fptw_pkg::VA_W-1:fptw_pkg::CANON_LSB] == '0) ||
                           (va_q[fptw_pkg::VA_W-1:fptw_pkg::CANON_LSB] == fptw_pkg::CANON_ONES);
  assign sts_o.present   = ram_rdata[fptw_pkg::PRESENT_BIT];
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_translated_q <= cmd_i.emit_ok;
      out_pa_q         <= cmd_i.emit_ok ? {entry_frame, va_q[fptw_pkg::OFFSET_W-1:0]} : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_translated_o = out_translated_q;
  assign out_phys_addr_o  = out_pa_q;

endmodule

// File: rtl/four_level_page_table_walker.sv
// Four-level page table walker. Write items (mode 0) load one 64-bit word into
// the local table store as they are accepted and give no result; words at or
// above the store size are dropped. Translate items (mode 1) give exactly one
// result: the block registers the address, checks that bits 63:48 are all zeros
// or all ones, then reads PML4, PDP, PD and PT entries from the single-port
// store, one read per cycle, each address built from the previous entry's frame.
// A successful translation passes through accept, canonical check with first
// read and four entry checks; its result is then registered, and the walker
// holds while the output slot is full. A non-canonical address gives its result
// from the canonical check; a clear present bit at PML4, PDP, PD or PT gives it
// from that level's entry check. Each read goes through the store's registered
// read port. One item is worked on at a time, but the result sits in an output
// register, so the next item is taken while it waits. The store powers up
// undefined and has no clearing pass: only read entries you have written. The
// root frame register (APB offset 0) must be written by the user only while
// idle; the block itself does not enforce it.
// Depends on fptw_pkg, fptw_in_if, fptw_out_if, fptw_ctrl and fptw_dp.
module four_level_page_table_walker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  fptw_in_if.sink                            item_i,
  fptw_out_if.source                         result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fptw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fptw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fptw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  fptw_pkg::cmd_t                   cmd;
  fptw_pkg::sts_t                   sts;
  logic [fptw_pkg::ROOT_W-1:0]      root_q;
  logic                             reg_sel;
  logic                             cfg_write;

  // APB register file: one register, zero wait states.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_write && reg_sel == fptw_pkg::REG_ROOT_TABLE_FRAME) begin
      // Keep the low bits; higher ones have no storage.
      root_q <= pwdata[fptw_pkg::ROOT_W-1:0];
    end
  end

  // Unmapped offsets read as zero.
  assign prdata = (reg_sel == fptw_pkg::REG_ROOT_TABLE_FRAME) ?
                  fptw_pkg::APB_DATA_W'(root_q) : '0;

  // Controller: owns sequencing and the input handshake.
  fptw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_mode_i  (item_i.mode),
    .item_ready_o (item_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Datapath: store, address mux and the result register driving the output beat.
  fptw_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .table_word_index_i (item_i.table_word_index),
    .entry_value_i      (item_i.entry_value),
    .virt_addr_i        (item_i.virt_addr),
    .root_table_frame_i (root_q),
    .out_ready_i        (result_o.ready),
    .out_valid_o        (result_o.valid),
    .out_translated_o   (result_o.translated),
    .out_phys_addr_o    (result_o.phys_addr)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for four_level_page_table_walker: a directed table, then
// random walks built on a shadow page store, checked beat by beat against a predictor.
// Depends on fptw_pkg, fptw_in_if, fptw_out_if and the walker RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fptw_pkg::*;

  // Byte addresses of the configuration port: the root frame and an unmapped slot.
  localparam logic [APB_ADDR_W-1:0] ROOT_REG_ADDR  = {REG_ROOT_TABLE_FRAME, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_REG_ADDR = {~REG_ROOT_TABLE_FRAME, 2'b00};

  localparam int unsigned LEVELS       = 4;
  localparam int unsigned TOP_IDX_MSB  = 47;
  localparam int unsigned VA_POOL_SIZE = 16;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned PHASE_ITEMS  = 457;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic                    mode;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [ENTRY_W-1:0]      entry;
    logic [VA_W-1:0]         va;
  } walk_item_t;

  typedef struct packed {
    logic            translated;
    logic [PA_W-1:0] pa;
  } walk_result_t;

  typedef struct {
    walk_item_t   item;
    bit           typed;
    walk_result_t want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fptw_in_if  item_bus ();
  fptw_out_if result_bus ();

  four_level_page_table_walker dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the block: page store, which words have been written, and the root frame.
  logic [ENTRY_W-1:0] page_store [STORE_WORDS];
  bit                 page_written [STORE_WORDS];
  logic [ROOT_W-1:0]  root_frame;

  // Walk results still owed by the block, oldest first.
  walk_result_t pending_results [$];
  dir_row_t     dir_rows [$];

  int unsigned fails;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned walks_ok;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_left;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Walk the shadow tables the way the hardware does: canonical check, then four
  // levels, stopping at the first entry whose present bit is clear.
  function automatic walk_result_t walk_tables(input logic [VA_W-1:0] va);
    walk_result_t       res;
    logic [FRAME_W-1:0] frame;
    logic [ENTRY_W-1:0] entry;
    res   = '0;
    entry = '0;
    if (va[VA_W-1:CANON_LSB] != '0 && va[VA_W-1:CANON_LSB] != CANON_ONES) return res;
    frame = root_frame;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      entry = page_store[{frame, va[TOP_IDX_MSB - TABLE_IDX_W * lvl -: TABLE_IDX_W]}];
      if (!entry[PRESENT_BIT]) return res;
      // Only the low frame bits address the store; the rest wrap.
      frame = entry[OFFSET_W +: FRAME_W];
    end
    res.translated = 1'b1;
    res.pa         = {entry[PA_W-1:OFFSET_W], va[OFFSET_W-1:0]};
    return res;
  endfunction

  // Apply one accepted input beat to the shadow state; translate beats owe a result.
  task automatic apply_beat(input walk_item_t it, input bit typed, input walk_result_t want);
    if (it.mode == MODE_WRITE) begin
      if (it.word_index < STORE_WORDS) begin
        page_store[it.word_index]   = it.entry;
        page_written[it.word_index] = 1'b1;
      end
    end else begin
      pending_results.push_back(typed ? want : walk_tables(it.va));
    end
  endtask

  // Offer one beat on the item channel. Call at a falling edge; returns at one.
  task automatic push_item(input walk_item_t it, input bit typed, input walk_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid            <= 1'b1;
    item_bus.mode             <= it.mode;
    item_bus.table_word_index <= it.word_index;
    item_bus.entry_value      <= it.entry;
    item_bus.virt_addr        <= it.va;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    apply_beat(it, typed, want);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Make sure every word the walk of va will read has been written, then translate va.
  // Fresh words are mostly present; a not-present word is sometimes rewritten as present
  // so that later walks go deeper.
  task automatic build_and_translate(input logic [VA_W-1:0] va);
    logic [FRAME_W-1:0]      frame;
    logic [WORD_INDEX_W-1:0] w;
    walk_item_t              it;
    bit                      stop;
    frame = root_frame;
    stop  = 1'b0;
    for (int lvl = 0; lvl < LEVELS && !stop; lvl++) begin
      w = {frame, va[TOP_IDX_MSB - TABLE_IDX_W * lvl -: TABLE_IDX_W]};
      if (!page_written[w] || (!page_store[w][PRESENT_BIT] && $urandom_range(0, 1) == 1)) begin
        it.mode       = MODE_WRITE;
        it.word_index = w;
        it.entry      = {$urandom, $urandom};
        it.va         = {$urandom, $urandom};
        it.entry[PRESENT_BIT] = page_written[w] ? 1'b1 : ($urandom_range(0, 99) < 88);
        push_item(it, 1'b0, '0);
      end
      stop  = !page_store[w][PRESENT_BIT];
      frame = page_store[w][OFFSET_W +: FRAME_W];
    end
    it.mode       = MODE_TRANSLATE;
    it.word_index = WORD_INDEX_W'($urandom);
    it.entry      = {$urandom, $urandom};
    it.va         = va;
    push_item(it, 1'b0, '0);
  endtask

  // APB write: setup, then access; the register takes the value at the access edge.
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr[APB_ADDR_W-1] == REG_ROOT_TABLE_FRAME) root_frame = data[ROOT_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read the root frame register back and compare with the shadow copy.
  task automatic check_root_readback();
    logic [APB_DATA_W-1:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ROOT_REG_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    want = APB_DATA_W'(root_frame);
    if (prdata !== want) begin
      fails++;
      $display("%0t: root frame readback: expected %h, actual %h", $time, want, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid, wait for every owed result, then let the walker settle.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_row(input logic mode, input logic [WORD_INDEX_W-1:0] idx,
                                  input logic [ENTRY_W-1:0] entry, input logic [VA_W-1:0] va,
                                  input bit typed, input logic ok, input logic [PA_W-1:0] pa);
    dir_row_t row;
    row.item  = '{mode: mode, word_index: idx, entry: entry, va: va};
    row.typed = typed;
    row.want  = '{translated: ok, pa: pa};
    dir_rows.push_back(row);
  endfunction

  // Result side: hold ready low through a requested hold-off, otherwise idle at random.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        result_bus.ready <= 1'b0;
        hold_off_left--;
      end else begin
        result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare every accepted result beat with the oldest owed result, field by field.
  always @(posedge clk_i) begin : result_check
    walk_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (result_bus.translated) walks_ok++;
      if (pending_results.size() == 0) begin
        fails++;
        $display("%0t: result beat with nothing owed: translated %b, phys_addr %h",
                 $time, result_bus.translated, result_bus.phys_addr);
      end else begin
        want = pending_results.pop_front();
        if (result_bus.translated !== want.translated) begin
          fails++;
          $display("%0t: translated: expected %b, actual %b",
                   $time, want.translated, result_bus.translated);
        end
        if (result_bus.phys_addr !== want.pa) begin
          fails++;
          $display("%0t: phys_addr: expected %h, actual %h",
                   $time, want.pa, result_bus.phys_addr);
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    walk_item_t       it;
    logic [VA_W-1:0]  va;
    logic [VA_W-1:0]  va_pool [VA_POOL_SIZE];
    int unsigned      pool_fill;
    int unsigned      pick;
    int unsigned      target;
    logic [APB_DATA_W-1:0] root_data;

    fails         = 0;
    items_sent    = 0;
    results_seen  = 0;
    walks_ok      = 0;
    pool_fill     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 0;
    root_frame    = '0;

    rst_ni                    = 1'b0;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    item_bus.valid            = 1'b0;
    item_bus.mode             = MODE_WRITE;
    item_bus.table_word_index = '0;
    item_bus.entry_value      = '0;
    item_bus.virt_addr        = '0;

    // Directed table. Build one chain of tables (frames 0 -> 1 -> 2 -> 3), then poke
    // each level's present bit, the canonical check and the extremes of the leaf.
    add_row(MODE_TRANSLATE, '0, '0, 64'h0001_0000_0000_0000, 1, 1'b0, '0);
    add_row(MODE_TRANSLATE, '1, '1, 64'hFFFE_FFFF_FFFF_FFFF, 1, 1'b0, '0);
    add_row(MODE_WRITE, 15'd0,    64'h0000_0000_0000_1001, '0, 0, 1'b0, '0);
    add_row(MODE_WRITE, 15'd512,  64'h0000_0000_0000_2001, '0, 0, 1'b0, '0);
    add_row(MODE_WRITE, 15'd1024, 64'h0000_0000_0000_3001, '0, 0, 1'b0, '0);
    add_row(MODE_WRITE, 15'd1536, 64'h000F_FFFF_FFFF_F001, '0, 0, 1'b0, '0);
    add_row(MODE_TRANSLATE, '0, '0, 64'h0000_0000_0000_0FFF, 1, 1'b1, 52'hF_FFFF_FFFF_FFFF);
    add_row(MODE_TRANSLATE, '0, '0, 64'hFFFF_0000_0000_0123, 1, 1'b1, 52'hF_FFFF_FFFF_F123);
    // Leaf with only the bits above the frame set: offset comes through alone.
    add_row(MODE_WRITE, 15'd1536, 64'hFFF0_0000_0000_0001, '0, 0, 1'b0, '0);
    add_row(MODE_TRANSLATE, '0, '0, 64'h0000_0000_0000_0ABC, 1, 1'b1, 52'h0_0000_0000_0ABC);
    // Fault at each level in turn: PT, PML4, PDP, PD.
    add_row(MODE_WRITE, 15'd1536, 64'hFFFF_FFFF_FFFF_FFFE, '0, 0, 1'b0, '0);
    add_row(MODE_TRANSLATE, '0, '0, 64'h0000_0000_0000_0000, 1, 1'b0, '0);
    add_row(MODE_WRITE, 15'd1, 64'h0, '0, 0, 1'b0, '0);
    add_row(MODE_TRANSLATE, '0, '0, 64'h0000_0080_0000_0000, 1, 1'b0, '0);
    add_row(MODE_WRITE, 15'd513, 64'h2, '0, 0, 1'b0, '0);
    add_row(MODE_TRANSLATE, '0, '0, 64'h0000_0000_4000_0000, 1, 1'b0, '0);
    add_row(MODE_WRITE, 15'd1025, 64'h0, '0, 0, 1'b0, '0);
    add_row(MODE_TRANSLATE, '0, '0, 64'h0000_0000_0020_0000, 1, 1'b0, '0);
    // Restore the leaf; the address field of a write beat is ignored.
    add_row(MODE_WRITE, 15'd1536, 64'h0000_0000_0123_4001, '1, 0, 1'b0, '0);
    // Table frame far beyond the store wraps back to frame 1.
    add_row(MODE_WRITE, 15'd2, 64'hFFFF_FFFF_FFC0_1001, '0, 0, 1'b0, '0);
    add_row(MODE_TRANSLATE, '0, '0, 64'h0000_0100_0000_0567, 1, 1'b1, 52'h0_0000_0123_4567);
    // Index and entry fields of a translate beat are ignored.
    add_row(MODE_TRANSLATE, '1, '1, 64'h0000_0000_0000_0567, 1, 1'b1, 52'h0_0000_0123_4567);
    add_row(MODE_WRITE, '1, '1, '1, 0, 1'b0, '0);

    // Hold reset, then release it away from the rising edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_root_readback();
    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Random phases. Each starts idle: drain, reprogram the root (all-ones first, zero
    // in the third), touch the unmapped register, then run mostly well-formed walks.
    target = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      root_data = (p == 0) ? '1 : (p == 2) ? '0 : $urandom;
      apb_write(ROOT_REG_ADDR, root_data);
      apb_write(SPARE_REG_ADDR, $urandom);
      check_root_readback();
      send_idle_pct = (p == 0) ? 24 : (p == 1) ? 74 : 0;
      recv_idle_pct = (p == 0) ? 74 : (p == 1) ? 24 : 0;
      // Stall results for a long stretch while items keep coming, to back up the input.
      if (p == 2) hold_off_left = HOLD_OFF_CYCLES;
      target += PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Stray write anywhere in the store.
          it.mode       = MODE_WRITE;
          it.word_index = WORD_INDEX_W'($urandom);
          it.entry      = {$urandom, $urandom};
          it.va         = {$urandom, $urandom};
          push_item(it, 1'b0, '0);
        end else if (pick < 14) begin
          // Non-canonical address: no table is read.
          it.mode       = MODE_TRANSLATE;
          it.word_index = WORD_INDEX_W'($urandom);
          it.entry      = {$urandom, $urandom};
          it.va         = {16'($urandom_range(1, 16'hFFFE)), $urandom, 16'($urandom)};
          push_item(it, 1'b0, '0);
        end else begin
          if (pool_fill != 0 && $urandom_range(0, 1) == 1) begin
            // Revisit a known mapping with a new offset, sometimes a new leaf index.
            va = va_pool[$urandom_range(0, pool_fill - 1)];
            va[OFFSET_W-1:0] = OFFSET_W'($urandom);
            if ($urandom_range(0, 3) == 0) va[20:12] = TABLE_IDX_W'($urandom);
          end else begin
            va = {($urandom_range(0, 1) == 1) ? CANON_ONES : 16'h0000, $urandom, 16'($urandom)};
            if (pool_fill < VA_POOL_SIZE) begin
              va_pool[pool_fill] = va;
              pool_fill++;
            end else begin
              va_pool[$urandom_range(0, VA_POOL_SIZE - 1)] = va;
            end
          end
          build_and_translate(va);
        end
      end
    end

    drain_results();
    $display("Run covered %0d item beats and %0d result beats (%0d walks completed).",
             items_sent, results_seen, walks_ok);
    $display("Root frames 0, 63 and random, level faults, wrap of large frames, stalls.");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/fptw_pkg.sv
rtl/fptw_in_if.sv
rtl/fptw_out_if.sv
rtl/fptw_ram.sv
rtl/fptw_ctrl.sv
rtl/fptw_dp.sv
rtl/four_level_page_table_walker.sv
verif/tb_top.sv
